@@ sv/drt_pkg.sv @@
package drt_pkg;

    localparam int MAX_RECTS = 8;
    localparam int SCREENS   = 2;
    localparam int ENTRIES   = MAX_RECTS * SCREENS;
    localparam int IDX_W     = $clog2(MAX_RECTS);
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);
    localparam int SCR_W     = (SCREENS > 1) ? $clog2(SCREENS) : 1;
    localparam int ENT_W     = $clog2(ENTRIES);
    localparam int EDGE_W    = 17;
    localparam int DIM_W     = 13;
    localparam int COST_W    = 38;

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_WHOLE = 2'd1;
    localparam logic [1:0] OP_TAKE  = 2'd2;
    localparam logic [1:0] OP_DRAIN = 2'd3;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [EDGE_W-1:0] l;
        logic signed [EDGE_W-1:0] t;
        logic signed [EDGE_W-1:0] r;
        logic signed [EDGE_W-1:0] b;
    } t_rect;

    // controller -> datapath
    typedef struct packed {
        logic             load;      // capture input rectangle
        logic             rd;        // read entry at idx
        logic             rd_best;   // read the entry picked by the cost scan instead
        logic [IDX_W-1:0] idx;
        logic             cost_first;
        logic             cost_upd;  // compare cost of entry read last cycle
        logic             wr_new;    // write input rect at idx
        logic             wr_merge;  // merge input rect into best
        logic             emit_clip; // hold clipped entry for output
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic contains;  // entry read last cycle contains input
        logic clip_ok;   // entry read last cycle survives clipping
    } t_dp_sts;

endpackage

@@ sv/drt_datapath.sv @@
module drt_datapath
    import drt_pkg::*;
(
    input  logic                    i_clk,
    input  logic [SCR_W-1:0]        i_scr,
    input  logic signed [15:0]      i_left,
    input  logic signed [15:0]      i_top,
    input  logic signed [15:0]      i_width,
    input  logic signed [15:0]      i_height,
    input  logic [DIM_W-1:0]        i_sw,
    input  logic [DIM_W-1:0]        i_sh,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic [DIM_W-1:0]        o_x,
    output logic [DIM_W-1:0]        o_y,
    output logic [DIM_W-1:0]        o_w,
    output logic [DIM_W-1:0]        o_h
);

    t_rect r_mem [ENTRIES];
    t_rect r_ent;
    t_rect r_in;
    logic [SCR_W-1:0] r_scr;
    logic [IDX_W-1:0] r_best;
    logic [IDX_W-1:0] r_ridx;
    logic signed [COST_W-1:0] r_min_cost;
    logic signed [COST_W-1:0] r_ua, r_ea;
    logic [IDX_W-1:0] r_cidx;
    logic r_cvalid;
    logic r_cfirst;
    logic [DIM_W-1:0] r_hx, r_hy, r_hw, r_hh;
    logic signed [EDGE_W:0] uw, uh, ew, eh;
    logic signed [2*EDGE_W+1:0] ua, ea;
    logic signed [COST_W-1:0] cost;
    logic signed [EDGE_W:0] cx1, cy1, cx2, cy2;
    logic [ENT_W-1:0] waddr, raddr;

    function automatic logic [ENT_W-1:0] addr(input logic [SCR_W-1:0] s,
                                              input logic [IDX_W-1:0] i);
        logic [ENT_W+SCR_W-1:0] a;
        a = (ENT_W+SCR_W)'(s) * (ENT_W+SCR_W)'(MAX_RECTS) + (ENT_W+SCR_W)'(i);
        return a[ENT_W-1:0];
    endfunction

    function automatic logic signed [EDGE_W-1:0] smin(input logic signed [EDGE_W-1:0] a,
                                                      input logic signed [EDGE_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [EDGE_W-1:0] smax(input logic signed [EDGE_W-1:0] a,
                                                      input logic signed [EDGE_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign raddr = addr(r_scr, i_cmd.rd_best ? r_best : i_cmd.idx);
    assign waddr = addr(r_scr, i_cmd.wr_new ? i_cmd.idx : r_best);

    // union and entry extents of the entry read last cycle
    assign uw = smax(r_ent.r, r_in.r) - smin(r_ent.l, r_in.l);
    assign uh = smax(r_ent.b, r_in.b) - smin(r_ent.t, r_in.t);
    assign ew = r_ent.r - r_ent.l;
    assign eh = r_ent.b - r_ent.t;
    assign ua = uw * uh;
    assign ea = ew * eh;
    assign cost = r_ua - r_ea;

    assign o_sts.contains = (r_in.l >= r_ent.l) && (r_in.t >= r_ent.t)
                         && (r_in.r <= r_ent.r) && (r_in.b <= r_ent.b);

    assign cx1 = (r_ent.l < 0) ? '0 : (EDGE_W+1)'(r_ent.l);
    assign cy1 = (r_ent.t < 0) ? '0 : (EDGE_W+1)'(r_ent.t);
    assign cx2 = ((EDGE_W+1)'(r_ent.r) > $signed({5'd0, i_sw}))
               ? $signed({5'd0, i_sw}) : (EDGE_W+1)'(r_ent.r);
    assign cy2 = ((EDGE_W+1)'(r_ent.b) > $signed({5'd0, i_sh}))
               ? $signed({5'd0, i_sh}) : (EDGE_W+1)'(r_ent.b);
    assign o_sts.clip_ok = (cx2 > cx1) && (cy2 > cy1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scr  <= i_scr;
            r_in.l <= EDGE_W'(i_left);
            r_in.t <= EDGE_W'(i_top);
            r_in.r <= EDGE_W'(i_left) + EDGE_W'(i_width);
            r_in.b <= EDGE_W'(i_top) + EDGE_W'(i_height);
        end
        if (i_cmd.rd) begin
            r_ent  <= r_mem[raddr];
            r_ridx <= i_cmd.idx;
        end
        // stage 2: products of the entry read last cycle
        r_ua     <= COST_W'(ua);
        r_ea     <= COST_W'(ea);
        r_cidx   <= r_ridx;
        r_cvalid <= i_cmd.cost_upd;
        r_cfirst <= i_cmd.cost_first;
        if (r_cvalid && (r_cfirst || cost < r_min_cost)) begin
            r_best     <= r_cidx;
            r_min_cost <= cost;
        end
        if (i_cmd.wr_new) begin
            r_mem[waddr] <= r_in;
        end else if (i_cmd.wr_merge) begin
            r_mem[waddr] <= '{l: smin(r_ent.l, r_in.l), t: smin(r_ent.t, r_in.t),
                               r: smax(r_ent.r, r_in.r), b: smax(r_ent.b, r_in.b)};
        end
        // hold the newest survivor; the output stage shows the one before it
        if (i_cmd.emit_clip) begin
            r_hx <= cx1[DIM_W-1:0];
            r_hy <= cy1[DIM_W-1:0];
            r_hw <= DIM_W'(cx2 - cx1);
            r_hh <= DIM_W'(cy2 - cy1);
        end
        o_x <= r_hx;
        o_y <= r_hy;
        o_w <= r_hw;
        o_h <= r_hh;
    end

endmodule

@@ sv/drt_ctrl.sv @@
module drt_ctrl
    import drt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_op,
    input  logic              i_screen,
    input  logic signed [15:0] i_width,
    input  logic signed [15:0] i_height,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd,
    output logic              o_sel_clip,
    output logic              o_strobe,
    output logic              o_dirty,
    output logic              o_rect_valid,
    output logic              o_whole_out,
    output logic              o_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_COST, S_WAIT, S_MERGE, S_DRAIN
    } t_state;

    t_state r_state;
    logic [1:0] r_op;
    logic [SCR_W-1:0] r_scr;
    logic r_whole [SCREENS];
    logic [CNT_W-1:0] r_cnt [SCREENS];
    logic [CNT_W-1:0] r_i;
    logic [1:0] r_wait;
    logic r_any;
    logic r_pend;   // read issued last cycle, entry valid now
    logic ok;
    logic [SCR_W-1:0] scr_in;

    assign scr_in = SCR_W'(i_screen);
    assign ok = ({31'd0, i_screen} < SCREENS);
    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.idx = r_i[IDX_W-1:0];
        o_cmd.load = start && !busy;
        unique case (r_state)
            S_SCAN: o_cmd.rd = (r_i < r_cnt[r_scr]) && !(r_pend && i_sts.contains);
            S_COST: begin
                o_cmd.rd = (r_i < CNT_W'(MAX_RECTS));
                o_cmd.cost_upd = r_pend;
                o_cmd.cost_first = r_pend && (r_i == CNT_W'(1));
            end
            S_WAIT: begin
                o_cmd.rd = (r_wait == 2'd0);
                o_cmd.rd_best = 1'b1;
            end
            S_MERGE: o_cmd.wr_merge = 1'b1;
            S_DRAIN: begin
                o_cmd.rd = (r_i < r_cnt[r_scr]);
                o_cmd.emit_clip = r_pend && i_sts.clip_ok;
            end
            default: ;
        endcase
        if (r_state == S_SCAN && !o_cmd.rd && !(r_pend && i_sts.contains)
            && r_cnt[r_scr] < CNT_W'(MAX_RECTS))
            o_cmd.wr_new = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int s = 0; s < SCREENS; s++) begin
                r_whole[s] <= 1'b0;
                r_cnt[s]   <= '0;
            end
            o_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_pend   <= o_cmd.rd;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_op <= i_op;
                    r_scr <= scr_in;
                    r_i <= '0;
                    r_any <= 1'b0;
                    o_dirty <= 1'b0; o_rect_valid <= 1'b0;
                    o_whole_out <= 1'b0; o_sel_clip <= 1'b0; o_last <= 1'b1;
                    unique case (i_op)
                        OP_MARK: if (ok && !r_whole[scr_in] && i_width > 0 && i_height > 0)
                            r_state <= S_SCAN;
                        OP_WHOLE: if (ok) r_whole[scr_in] <= 1'b1;
                        OP_TAKE: begin
                            o_strobe <= 1'b1;
                            if (ok) begin
                                o_dirty <= r_whole[scr_in] || (r_cnt[scr_in] != '0);
                                r_whole[scr_in] <= 1'b0;
                                r_cnt[scr_in] <= '0;
                            end
                        end
                        default: begin
                            if (!ok) o_strobe <= 1'b1;
                            else if (r_whole[scr_in]) begin
                                o_strobe <= 1'b1;
                                o_rect_valid <= 1'b1;
                                o_whole_out <= 1'b1;
                                r_whole[scr_in] <= 1'b0;
                                r_cnt[scr_in] <= '0;
                            end else r_state <= S_DRAIN;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (r_pend && i_sts.contains) r_state <= S_IDLE;
                    else if (o_cmd.rd) r_i <= r_i + 1'b1;
                    else if (o_cmd.wr_new) begin
                        r_cnt[r_scr] <= r_cnt[r_scr] + 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= '0;
                        r_state <= S_COST;
                    end
                end
                S_COST: begin
                    if (o_cmd.rd) r_i <= r_i + 1'b1;
                    else begin
                        r_wait <= 2'd2;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    // let the last cost retire, then fetch the best entry
                    if (r_wait != 2'd0) r_wait <= r_wait - 1'b1;
                    else r_state <= S_MERGE;
                end
                S_MERGE: r_state <= S_IDLE;
                S_DRAIN: begin
                    if (o_cmd.rd) r_i <= r_i + 1'b1;
                    if (o_cmd.emit_clip) r_any <= 1'b1;
                    // emit a held result once the next survivor or the end is known
                    if (!o_cmd.rd && !r_pend) begin
                        r_cnt[r_scr] <= '0;
                        r_state <= S_IDLE;
                        o_strobe <= 1'b1;
                        o_last <= 1'b1;
                        o_rect_valid <= r_any;
                        o_sel_clip <= r_any;
                    end else if (r_pend && i_sts.clip_ok && r_any) begin
                        o_strobe <= 1'b1;
                        o_last <= 1'b0;
                        o_rect_valid <= 1'b1;
                        o_sel_clip <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(r_state == S_SCAN || r_state == S_COST))
        else $error("result during mark");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CNT_W'(MAX_RECTS))
        else $error("count overflow");
    a_merge_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MERGE |-> r_cnt[r_scr] == CNT_W'(MAX_RECTS))
        else $error("merge with free slot");
`endif

endmodule

@@ sv/dirty_rectangle_tracker.sv @@
// Mark: ignored up front, else a scan that reads one entry per cycle, then an insert
// or a merge. Take, whole mark: handled in idle; a whole mark gives no result, a take
// shows it in the next cycle. Drain: the last result shows in the cycle busy drops.
// The receiver cannot stall results; a new item waits only on busy.
// Synchronous active-low reset clears flags and counts; entry storage is not cleared.
module dirty_rectangle_tracker
    import drt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic               i_screen,
    input  logic signed [15:0] i_left,
    input  logic signed [15:0] i_top,
    input  logic signed [15:0] i_width,
    input  logic signed [15:0] i_height,
    output logic               o_strobe,
    output logic               o_dirty,
    output logic               o_rect_valid,
    output logic [12:0]        o_rect_x,
    output logic [12:0]        o_rect_y,
    output logic [12:0]        o_rect_w,
    output logic [12:0]        o_rect_h,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [DIM_W-1:0] r_sw, r_sh;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic sel_clip, whole_out;
    logic [DIM_W-1:0] dx, dy, dw, dh;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= DIM_W'(320);
            r_sh <= DIM_W'(240);
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_WIDTH) r_sw <= pwdata[DIM_W-1:0];
            else r_sh <= pwdata[DIM_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
            prdata = (paddr[2] == REG_HEIGHT) ? {19'd0, r_sh} : {19'd0, r_sw};
    end

    drt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy, .i_op, .i_screen, .i_width, .i_height,
        .i_sts(sts), .o_cmd(cmd), .o_sel_clip(sel_clip), .o_strobe,
        .o_dirty, .o_rect_valid, .o_whole_out(whole_out), .o_last
    );

    drt_datapath u_dp (
        .i_clk, .i_scr(SCR_W'(i_screen)), .i_left, .i_top, .i_width, .i_height,
        .i_sw(r_sw), .i_sh(r_sh), .i_cmd(cmd), .o_sts(sts),
        .o_x(dx), .o_y(dy), .o_w(dw), .o_h(dh)
    );

    assign o_rect_x = sel_clip ? dx : '0;
    assign o_rect_y = sel_clip ? dy : '0;
    assign o_rect_w = sel_clip ? dw : (whole_out ? r_sw : '0);
    assign o_rect_h = sel_clip ? dh : (whole_out ? r_sh : '0);

endmodule

@@ sim/dirty_rectangle_tracker_test.sv @@
`timescale 1ns / 100ps

module dirty_rectangle_tracker_test
    import drt_pkg::*;
();

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic        dirty;
        logic        rect_valid;
        logic [12:0] x;
        logic [12:0] y;
        logic [12:0] w;
        logic [12:0] h;
        logic        last;
    } t_region;

    class dirty_scoreboard;
        int unsigned scr_w = 320;
        int unsigned scr_h = 240;
        bit          whole[SCREENS];
        int          count[SCREENS];
        int          le[SCREENS][MAX_RECTS];
        int          te[SCREENS][MAX_RECTS];
        int          re[SCREENS][MAX_RECTS];
        int          be[SCREENS][MAX_RECTS];
        t_region     pending[$];
        int          errors;

        function void push(logic d, logic v, int x, int y, int w, int h, logic lst);
            t_region r;
            r.dirty = d; r.rect_valid = v;
            r.x = x[12:0]; r.y = y[12:0]; r.w = w[12:0]; r.h = h[12:0];
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void add_rect(int s, int x, int y, int w, int h);
            int x2;
            int y2;
            int pick;
            longint min_cost;
            longint cost;
            x2 = x + w;
            y2 = y + h;
            if (w <= 0 || h <= 0 || whole[s]) return;
            for (int i = 0; i < count[s]; i++)
                if (x >= le[s][i] && y >= te[s][i] && x2 <= re[s][i] && y2 <= be[s][i])
                    return;
            if (count[s] < MAX_RECTS) begin
                le[s][count[s]] = x; te[s][count[s]] = y;
                re[s][count[s]] = x2; be[s][count[s]] = y2;
                count[s]++;
                return;
            end
            pick = 0;
            min_cost = 0;
            for (int i = 0; i < MAX_RECTS; i++) begin
                cost = longint'((re[s][i] > x2 ? re[s][i] : x2) - (le[s][i] < x ? le[s][i] : x))
                     * longint'((be[s][i] > y2 ? be[s][i] : y2) - (te[s][i] < y ? te[s][i] : y))
                     - longint'(re[s][i] - le[s][i]) * longint'(be[s][i] - te[s][i]);
                if (i == 0 || cost < min_cost) begin
                    pick = i;
                    min_cost = cost;
                end
            end
            if (x < le[s][pick]) le[s][pick] = x;
            if (y < te[s][pick]) te[s][pick] = y;
            if (x2 > re[s][pick]) re[s][pick] = x2;
            if (y2 > be[s][pick]) be[s][pick] = y2;
        endfunction

        function void drain_screen(int s);
            int x1, y1, x2, y2;
            int first;
            first = pending.size();
            if (whole[s]) begin
                push(0, 1, 0, 0, int'(scr_w), int'(scr_h), 1);
            end else begin
                for (int i = 0; i < count[s]; i++) begin
                    x1 = le[s][i] < 0 ? 0 : le[s][i];
                    y1 = te[s][i] < 0 ? 0 : te[s][i];
                    x2 = re[s][i] > int'(scr_w) ? int'(scr_w) : re[s][i];
                    y2 = be[s][i] > int'(scr_h) ? int'(scr_h) : be[s][i];
                    if (x2 > x1 && y2 > y1) push(0, 1, x1, y1, x2 - x1, y2 - y1, 0);
                end
                if (pending.size() == first) push(0, 0, 0, 0, 0, 0, 1);
                else pending[pending.size() - 1].last = 1;
            end
            whole[s] = 0;
            count[s] = 0;
        endfunction

        // note one accepted transfer and queue what it produces
        function void note_transfer(logic [1:0] op, logic scr, shortint l, shortint t,
                                    shortint w, shortint h);
            int s;
            s = int'(scr);
            case (op)
                OP_MARK:  add_rect(s, l, t, w, h);
                OP_WHOLE: whole[s] = 1;
                OP_TAKE: begin
                    push(whole[s] || count[s] > 0, 0, 0, 0, 0, 0, 1);
                    whole[s] = 0;
                    count[s] = 0;
                end
                default:  drain_screen(s);
            endcase
        endfunction

        function void check_region(t_region got);
            t_region want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result dirty=%0d valid=%0d x=%0d y=%0d w=%0d h=%0d",
                         $time, got.dirty, got.rect_valid, got.x, got.y, got.w, got.h);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want != got) begin
                $display("%0t: mismatch expected dirty=%0d valid=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
                         $time, want.dirty, want.rect_valid, want.x, want.y, want.w, want.h,
                         want.last);
                $display("%0t:          actual   dirty=%0d valid=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
                         $time, got.dirty, got.rect_valid, got.x, got.y, got.w, got.h,
                         got.last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [1:0]         i_op = OP_MARK;
    logic               i_screen = 0;
    logic signed [15:0] i_left = 0;
    logic signed [15:0] i_top = 0;
    logic signed [15:0] i_width = 0;
    logic signed [15:0] i_height = 0;
    logic               o_strobe;
    logic               o_dirty;
    logic               o_rect_valid;
    logic [12:0]        o_rect_x;
    logic [12:0]        o_rect_y;
    logic [12:0]        o_rect_w;
    logic [12:0]        o_rect_h;
    logic               o_last;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [2:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    dirty_scoreboard tracker_model = new();
    int  idle_pct = 11;
    int  quiet_cycles = 0;

    dirty_rectangle_tracker DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            tracker_model.check_region('{o_dirty, o_rect_valid, o_rect_x, o_rect_y,
                                         o_rect_w, o_rect_h, o_last});
        if ((start && !busy) || o_strobe || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, int unsigned value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_WIDTH) tracker_model.scr_w = value & 32'h1FFF;
        else tracker_model.scr_h = value & 32'h1FFF;
    endtask

    task automatic send(logic [1:0] op, logic scr, shortint l = 0, shortint t = 0,
                        shortint w = 0, shortint h = 0);
        start <= 1; i_op <= op; i_screen <= scr;
        i_left <= l; i_top <= t; i_width <= w; i_height <= h;
        do @(posedge i_clk); while (busy);
        tracker_model.note_transfer(op, scr, l, t, w, h);
        // occasional gap before the next transfer
        if ($urandom_range(99) < idle_pct) begin
            start <= 0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 0;
        @(posedge i_clk);
        while (tracker_model.pending.size() != 0) @(posedge i_clk);
        // a mark can still be scanning with no result due
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic directed_items();
        send(OP_TAKE, 0);
        send(OP_DRAIN, 1);
        send(OP_MARK, 0, 10, 10, 0, 5);
        send(OP_MARK, 0, 10, 10, 5, -32768);
        send(OP_MARK, 0, 10, 10, 20, 20);
        send(OP_MARK, 0, 12, 12, 4, 4);
        send(OP_MARK, 0, -32768, -32768, 32767, 32767);
        send(OP_MARK, 0, 32767, 32767, 32767, 32767);
        send(OP_MARK, 0, -5, 100, 30, 8);
        send(OP_MARK, 0, 300, 200, 500, 500);
        send(OP_MARK, 0, 50, 50, 1, 1);
        send(OP_MARK, 0, 60, 60, 1, 1);
        send(OP_MARK, 0, 70, 70, 1, 1);
        // table is full: these merge
        send(OP_MARK, 0, 55, 55, 2, 2);
        send(OP_MARK, 0, 1000, 1000, 3, 3);
        send(OP_TAKE, 1);
        send(OP_DRAIN, 0);
        send(OP_MARK, 1, 5, 5, 5, 5);
        send(OP_WHOLE, 1);
        send(OP_MARK, 1, 0, 0, 9, 9);
        send(OP_TAKE, 1);
        send(OP_WHOLE, 0);
        send(OP_DRAIN, 0);
        send(OP_DRAIN, 0);
    endtask

    task automatic random_items(int n);
        shortint l, t, w, h;
        int      pick;
        for (int i = 0; i < n; i++) begin
            idle_pct = (i >= n / 3 && i < 2 * n / 3) ? 0 : 11;
            if (i == n / 2) settle();
            pick = $urandom_range(99);
            if (pick < 10) begin
                l = shortint'($urandom); t = shortint'($urandom);
                w = shortint'($urandom); h = shortint'($urandom);
                send(OP_MARK, 1'($urandom_range(1)), l, t, w, h);
            end else if (pick < 72) begin
                l = shortint'(int'($urandom_range(400)) - 60);
                t = shortint'(int'($urandom_range(300)) - 40);
                w = shortint'(int'($urandom_range(120)) - 5);
                h = shortint'(int'($urandom_range(120)) - 5);
                send(OP_MARK, 1'($urandom_range(1)), l, t, w, h);
            end else if (pick < 76) begin
                send(OP_WHOLE, 1'($urandom_range(1)));
            end else if (pick < 84) begin
                send(OP_TAKE, 1'($urandom_range(1)));
            end else begin
                send(OP_DRAIN, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed_items();
        random_items(12);
        settle();
        write_reg(REG_WIDTH, 4096);
        write_reg(REG_HEIGHT, 4096);
        directed_items();
        random_items(6);
        settle();
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 1);
        directed_items();
        random_items(6);
        settle();
        write_reg(REG_WIDTH, $urandom_range(4096, 1));
        write_reg(REG_HEIGHT, $urandom_range(4096, 1));
        random_items(24);
        settle();
        if (tracker_model.errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
sv/drt_pkg.sv
sv/drt_datapath.sv
sv/drt_ctrl.sv
sv/dirty_rectangle_tracker.sv
sim/dirty_rectangle_tracker_test.sv
